FILE: rtl/vpc_pkg.sv
// Shared types, constants and threshold tables of the vehicle predicate classifier.
package vpc_pkg;

  // Vehicle history slots, ID width and derived widths
  localparam int VEHICLE_SLOTS = 256;
  localparam int ID_W          = 8;
  localparam int ID_N          = 1 << ID_W;
  localparam int SLOT_W        = $clog2(VEHICLE_SLOTS);
  localparam int HIST_W        = 7;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Relative position classes; POS_UNSEEN selects the default thresholds
  localparam logic [2:0] POS_BEHIND       = 3'd0;
  localparam logic [2:0] POS_CLOSE_BEHIND = 3'd1;
  localparam logic [2:0] POS_SAME         = 3'd2;
  localparam logic [2:0] POS_CLOSE_FRONT  = 3'd3;
  localparam logic [2:0] POS_FRONT        = 3'd4;
  localparam logic [2:0] POS_UNSEEN       = 3'd5;

  // Relative speed classes
  localparam logic [1:0] SPD_SLOWER = 2'd0;
  localparam logic [1:0] SPD_SAME   = 2'd1;
  localparam logic [1:0] SPD_FASTER = 2'd2;
  localparam logic [1:0] SPD_UNSEEN = 2'd3;

  // Acceleration classes
  localparam logic [1:0] ACC_BRAKE  = 2'd0;
  localparam logic [1:0] ACC_NONE   = 2'd1;
  localparam logic [1:0] ACC_ACCEL  = 2'd2;
  localparam logic [1:0] ACC_UNSEEN = 2'd3;

  // Lane change classes
  localparam logic [1:0] LC_NONE  = 2'd0;
  localparam logic [1:0] LC_LEFT  = 2'd1;
  localparam logic [1:0] LC_RIGHT = 2'd2;

  // One classified record
  typedef struct packed {
    logic [ID_W-1:0] vehicle_id;
    logic [2:0]      rel_pos;
    logic [1:0]      rel_spd;
    logic [1:0]      accel;
    logic [1:0]      lane_chg;
    logic [3:0]      lane;
    logic            stable;
  } rec_t;

  // Transfer from the front into the queue
  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

  // Map of vehicle ID to history slot, built at elaboration
  typedef logic [SLOT_W-1:0] slot_tab_t [ID_N];

  function automatic slot_tab_t build_slot_tab();
    slot_tab_t t;
    for (int i = 0; i < ID_N; i++) begin
      t[i] = SLOT_W'(i % VEHICLE_SLOTS);
    end
    return t;
  endfunction

  localparam slot_tab_t SLOT_TAB = build_slot_tab();

  // Position limits in quarters of the reference speed, by previous class
  function automatic logic signed [3:0] pos_limit(input logic [2:0] prev,
                                                  input logic [1:0] k);
    logic signed [3:0] lim [4];
    case (prev)
      POS_BEHIND:       lim = '{-4'sd4, -4'sd1, 4'sd2, 4'sd5};
      POS_CLOSE_BEHIND: lim = '{-4'sd5, -4'sd1, 4'sd2, 4'sd5};
      POS_SAME:         lim = '{-4'sd4, -4'sd2, 4'sd2, 4'sd5};
      POS_CLOSE_FRONT:  lim = '{-4'sd4, -4'sd1, 4'sd1, 4'sd5};
      POS_FRONT:        lim = '{-4'sd4, -4'sd1, 4'sd2, 4'sd4};
      default:          lim = '{-4'sd5, -4'sd2, 4'sd2, 4'sd5};
    endcase
    return lim[k];
  endfunction

  // Speed limits in twentieths of the reference speed, by previous class
  function automatic logic [4:0] spd_limit(input logic [1:0] prev, input logic k);
    logic [4:0] lim [2];
    case (prev)
      SPD_SLOWER: lim = '{5'd18, 5'd25};
      SPD_SAME:   lim = '{5'd15, 5'd25};
      SPD_FASTER: lim = '{5'd15, 5'd22};
      default:    lim = '{5'd15, 5'd25};
    endcase
    return lim[k];
  endfunction

  // Raw acceleration limits, by previous class
  function automatic logic signed [2:0] acc_limit(input logic [1:0] prev, input logic k);
    logic signed [2:0] lim [2];
    case (prev)
      ACC_BRAKE: lim = '{-3'sd1, 3'sd2};
      ACC_NONE:  lim = '{-3'sd2, 3'sd2};
      ACC_ACCEL: lim = '{-3'sd2, 3'sd1};
      default:   lim = '{-3'sd2, 3'sd2};
    endcase
    return lim[k];
  endfunction

endpackage

FILE: rtl/vpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/vpc_front.sv
// Front end: accepts records, tracks frame and reference state, classifies.
module vpc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [7:0]            in_vehicle_id,
  input  logic signed [31:0]    in_x_position,
  input  logic [15:0]           in_speed,
  input  logic signed [15:0]    in_acceleration,
  input  logic [3:0]            in_lane,
  input  logic signed [7:0]     in_lane_change,
  input  logic                  in_stable,
  output vpc_pkg::push_t        push,
  input  logic                  push_ready
);

  import vpc_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE  = 2'b01,
    F_CLASS = 2'b10
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic accept, push_fire;

  // Frame and reference state
  logic [VEHICLE_SLOTS-1:0] seen_last_r, seen_this_r;
  logic signed [31:0]       refpos_r;
  logic [15:0]              refspd_r;

  // Captured record
  logic                     cmd_r;
  logic [ID_W-1:0]          id_r;
  logic [SLOT_W-1:0]        slot_r;
  logic signed [32:0]       d_r;
  logic [20:0]              s20_r;
  logic signed [15:0]       acc_r;
  logic [3:0]               lane_r;
  logic [1:0]               lc_r;
  logic                     stable_r;

  logic [SLOT_W-1:0]        slot_in;
  logic [HIST_W-1:0]        hist_rd;

  // Classification
  logic                     seen;
  logic [2:0]               pp;
  logic [1:0]               ps, pa;
  logic signed [34:0]       d4;
  logic signed [20:0]       vs;
  logic signed [20:0]       plim [4];
  logic [3:0]               pos_lt;
  logic [20:0]              slim [2];
  logic [1:0]               spd_lt;
  logic [1:0]               acc_lt;
  logic [2:0]               rp;
  logic [1:0]               rs, ra;

  assign slot_in   = SLOT_TAB[in_vehicle_id];
  assign in_ready  = (state_r == F_IDLE);
  assign accept    = in_valid && in_ready;
  assign push_fire = push.valid && push_ready;

  // Sequence one record: capture, then classify and hand over
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept) state_nxt = F_CLASS;
      F_CLASS: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the frame on a reference record; mark the slot when its result leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_last_r <= '0;
      seen_this_r <= '0;
      refpos_r    <= '0;
      refspd_r    <= 16'd1;
    end else if (accept && in_command) begin
      seen_last_r <= seen_this_r;
      seen_this_r <= '0;
      refpos_r    <= in_x_position;
      refspd_r    <= (in_speed == 16'd0) ? 16'd1 : in_speed;
    end else if (push_fire) begin
      seen_this_r[slot_r] <= 1'b1;
    end
  end

  // Capture the record with its position offset and scaled speed
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_command;
      id_r     <= in_vehicle_id;
      slot_r   <= slot_in;
      d_r      <= 33'(in_x_position) - 33'(refpos_r);
      s20_r    <= 21'({in_speed, 4'b0}) + 21'({in_speed, 2'b0});
      acc_r    <= in_acceleration;
      lane_r   <= in_lane;
      lc_r     <= in_lane_change[7] ? LC_RIGHT :
                  ((in_lane_change != 8'sd0) ? LC_LEFT : LC_NONE);
      stable_r <= in_stable;
    end
  end

  // Class history table
  vpc_ram #(
    .WIDTH(HIST_W),
    .DEPTH(VEHICLE_SLOTS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (push_fire),
    .wr_addr (slot_r),
    .wr_data ({ra, rs, rp}),
    .rd_en   (accept),
    .rd_addr (slot_in),
    .rd_data (hist_rd)
  );

  // Pick previous classes, falling back to defaults for unseen or corrupt entries
  always_comb begin
    seen = seen_last_r[slot_r];
    pp   = POS_UNSEEN;
    ps   = SPD_UNSEEN;
    pa   = ACC_UNSEEN;
    if (seen) begin
      pp = (hist_rd[2:0] > POS_FRONT)  ? POS_UNSEEN : hist_rd[2:0];
      ps = (hist_rd[4:3] > SPD_FASTER) ? SPD_UNSEEN : hist_rd[4:3];
      pa = (hist_rd[6:5] > ACC_ACCEL)  ? ACC_UNSEEN : hist_rd[6:5];
    end
  end

  // Compare against threshold multiples of the reference speed
  always_comb begin
    d4 = $signed({d_r, 2'b00});
    vs = $signed({5'b0, refspd_r});
    for (int k = 0; k < 4; k++) begin
      plim[k]   = 21'(pos_limit(pp, 2'(k))) * vs;
      pos_lt[k] = d4 < 35'(plim[k]);
    end
    for (int k = 0; k < 2; k++) begin
      slim[k]   = {16'b0, spd_limit(ps, 1'(k))} * {5'b0, refspd_r};
      spd_lt[k] = s20_r < slim[k];
      acc_lt[k] = acc_r < 16'(acc_limit(pa, 1'(k)));
    end
  end

  // Resolve classes: first unreached threshold wins; a command is SAME pos/spd
  always_comb begin
    if (cmd_r) begin
      rp = POS_SAME;
      rs = SPD_SAME;
    end else begin
      priority if (pos_lt[0]) rp = POS_BEHIND;
      else if (pos_lt[1])     rp = POS_CLOSE_BEHIND;
      else if (pos_lt[2])     rp = POS_SAME;
      else if (pos_lt[3])     rp = POS_CLOSE_FRONT;
      else                    rp = POS_FRONT;
      priority if (spd_lt[0]) rs = SPD_SLOWER;
      else if (spd_lt[1])     rs = SPD_SAME;
      else                    rs = SPD_FASTER;
    end
    priority if (acc_lt[0]) ra = ACC_BRAKE;
    else if (acc_lt[1])     ra = ACC_NONE;
    else                    ra = ACC_ACCEL;
  end

  // Hand the record to the queue
  always_comb begin
    push.valid          = (state_r == F_CLASS);
    push.rec.vehicle_id = id_r;
    push.rec.rel_pos    = rp;
    push.rec.rel_spd    = rs;
    push.rec.accel      = ra;
    push.rec.lane_chg   = lc_r;
    push.rec.lane       = lane_r;
    push.rec.stable     = stable_r;
  end

endmodule

FILE: rtl/vpc_fifo.sv
// Short record queue between the classifier front and the output back end.
module vpc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  vpc_pkg::push_t push,
  output logic           push_ready,
  output logic           pop_valid,
  output vpc_pkg::rec_t  pop_rec,
  input  logic           pop_ready
);

  import vpc_pkg::*;

  rec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              wr_fire, rd_fire;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_rec    = mem_r[rd_ptr_r];
  assign wr_fire    = push.valid && push_ready;
  assign rd_fire    = pop_valid && pop_ready;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_fire) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_fire) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_fire && !rd_fire) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_fire && !wr_fire) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store an incoming record
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

endmodule

FILE: rtl/vpc_back.sv
// Back end: drains the queue into the output register and delivers results.
module vpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  input  vpc_pkg::rec_t       pop_rec,
  output logic                pop_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_vehicle_id_out,
  output logic [2:0]          out_relative_position,
  output logic [1:0]          out_relative_speed,
  output logic [1:0]          out_accel_class,
  output logic [1:0]          out_lane_change_class,
  output logic [3:0]          out_lane_out,
  output logic                out_stable_out
);

  import vpc_pkg::*;

  logic out_valid_r, out_valid_nxt;
  rec_t out_rec_r;
  logic pop_fire;

  // Take a new record whenever the output register is empty or being drained
  assign pop_ready = !out_valid_r || out_ready;
  assign pop_fire  = pop_valid && pop_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      out_rec_r <= pop_rec;
    end
  end

  // Drive the result ports
  assign out_valid             = out_valid_r;
  assign out_vehicle_id_out    = out_rec_r.vehicle_id;
  assign out_relative_position = out_rec_r.rel_pos;
  assign out_relative_speed    = out_rec_r.rel_spd;
  assign out_accel_class       = out_rec_r.accel;
  assign out_lane_change_class = out_rec_r.lane_chg;
  assign out_lane_out          = out_rec_r.lane;
  assign out_stable_out        = out_rec_r.stable;

endmodule

FILE: rtl/vehicle_predicate_classifier.sv
// Top level of the vehicle predicate classifier: front, queue, back and checks.
//
// Each record passes the front end's capture state, which reads the class
// history RAM, and its classify state, which writes the history entry back, so
// a new record is taken only once the current one is in the queue. The
// registered history read followed by its write-back sets this pacing. A result
// moves from the capture registers through the queue into the output register,
// and the two-entry queue and output register let the front keep going while
// the result side stalls. A record with command set starts a new frame and
// becomes the reference; history entries need no clearing after reset.
module vehicle_predicate_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [7:0]         in_vehicle_id,
  input  logic signed [31:0] in_x_position,
  input  logic [15:0]        in_speed,
  input  logic signed [15:0] in_acceleration,
  input  logic [3:0]         in_lane,
  input  logic signed [7:0]  in_lane_change,
  input  logic               in_stable,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_vehicle_id_out,
  output logic [2:0]         out_relative_position,
  output logic [1:0]         out_relative_speed,
  output logic [1:0]         out_accel_class,
  output logic [1:0]         out_lane_change_class,
  output logic [3:0]         out_lane_out,
  output logic               out_stable_out
);

  import vpc_pkg::*;

  push_t push_s;
  logic  push_ready;
  logic  q_valid, q_ready;
  rec_t  q_rec;

  vpc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_vehicle_id   (in_vehicle_id),
    .in_x_position   (in_x_position),
    .in_speed        (in_speed),
    .in_acceleration (in_acceleration),
    .in_lane         (in_lane),
    .in_lane_change  (in_lane_change),
    .in_stable       (in_stable),
    .push            (push_s),
    .push_ready      (push_ready)
  );

  vpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_s),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_rec    (q_rec),
    .pop_ready  (q_ready)
  );

  vpc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .pop_valid             (q_valid),
    .pop_rec               (q_rec),
    .pop_ready             (q_ready),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_vehicle_id_out    (out_vehicle_id_out),
    .out_relative_position (out_relative_position),
    .out_relative_speed    (out_relative_speed),
    .out_accel_class       (out_accel_class),
    .out_lane_change_class (out_lane_change_class),
    .out_lane_out          (out_lane_out),
    .out_stable_out        (out_stable_out)
  );

  // The front holds off the next transfer while it classifies
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in back-to-back cycles");

  // One history write per record: no two queue pushes in a row
  a_push_gap: assert property (@(posedge clk) disable iff (!rst_n)
    push_s.valid && push_ready |=> !(push_s.valid && push_ready))
    else $error("front pushed two records in consecutive cycles");

  // A waiting queue entry fills an empty output register at once
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !out_valid |=> out_valid)
    else $error("queued record not moved to the output register");

endmodule
